// ===== sv/aci_pkg.sv =====
// Shared types and constants for the table interpolator.
package aci_pkg;

   localparam int RAW_W    = 12;
   localparam int TEMP_W   = 16;
   localparam int IDX_W    = 5;
   localparam int OUT_W    = 24;
   localparam int FS_W     = 17;
   localparam int SCALE_SH = 8;
   localparam int DRAW_W   = RAW_W + 1;
   localparam int DV_W     = TEMP_W + 1;
   localparam int PROD_W   = DRAW_W + DV_W;
   localparam int NUM_W    = PROD_W + SCALE_SH;
   localparam int SUM_W    = NUM_W + 2;

   localparam logic REQ_LOAD    = 1'b0;
   localparam logic REQ_CONVERT = 1'b1;

   typedef struct packed {
      logic                     valid;
      logic                     found;
      logic                     direct;
      logic [RAW_W-1:0]         sample;
      logic [RAW_W-1:0]         prev_raw;
      logic signed [TEMP_W-1:0] prev_temp;
      logic [RAW_W-1:0]         lo_raw;
      logic signed [TEMP_W-1:0] lo_temp;
      logic [RAW_W-1:0]         hi_raw;
      logic signed [TEMP_W-1:0] hi_temp;
   } probe_type;

endpackage

// ===== sv/aci_cell.sv =====
// One breakpoint cell: holds an entry and passes the search probe on.
module aci_cell #(
   parameter int  FULL_SCALE = 4095,
   parameter bit  IS_FIRST   = 1'b0,
   parameter bit  IS_LAST    = 1'b0
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             wr_en,
   input  logic [aci_pkg::RAW_W-1:0]        wr_raw,
   input  logic signed [aci_pkg::TEMP_W-1:0] wr_temp,
   input  logic [aci_pkg::RAW_W-1:0]        next_raw,
   input  logic signed [aci_pkg::TEMP_W-1:0] next_temp,
   output logic [aci_pkg::RAW_W-1:0]        own_raw,
   output logic signed [aci_pkg::TEMP_W-1:0] own_temp,
   input  aci_pkg::probe_type               probe_in,
   output aci_pkg::probe_type               probe_out
);

   logic [aci_pkg::RAW_W-1:0]         raw_ff;
   logic signed [aci_pkg::TEMP_W-1:0] temp_ff;
   aci_pkg::probe_type                probe_ff, probe_in_next;
   logic                              hit, direct;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         raw_ff  <= wr_raw;
         temp_ff <= wr_temp;
      end
   end

   assign own_raw  = raw_ff;
   assign own_temp = temp_ff;

   assign hit    = probe_in.valid && !probe_in.found && ((raw_ff >= probe_in.sample) || IS_LAST);
   assign direct = (raw_ff == probe_in.sample)
                 || ({{(aci_pkg::FS_W-aci_pkg::RAW_W){1'b0}}, raw_ff} >= aci_pkg::FS_W'(FULL_SCALE));

   always_comb begin
      probe_in_next           = probe_in;
      probe_in_next.prev_raw  = raw_ff;
      probe_in_next.prev_temp = temp_ff;
      if (hit) begin
         probe_in_next.found  = 1'b1;
         probe_in_next.direct = direct;
         if (direct) begin
            probe_in_next.lo_raw  = raw_ff;
            probe_in_next.lo_temp = temp_ff;
            probe_in_next.hi_raw  = raw_ff;
            probe_in_next.hi_temp = temp_ff;
         end else if (IS_FIRST) begin
            probe_in_next.lo_raw  = raw_ff;
            probe_in_next.lo_temp = temp_ff;
            probe_in_next.hi_raw  = next_raw;
            probe_in_next.hi_temp = next_temp;
         end else begin
            probe_in_next.lo_raw  = probe_in.prev_raw;
            probe_in_next.lo_temp = probe_in.prev_temp;
            probe_in_next.hi_raw  = raw_ff;
            probe_in_next.hi_temp = temp_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         probe_ff <= '0;
      end else begin
         probe_ff <= probe_in_next;
      end
   end

   assign probe_out = probe_ff;

endmodule

// ===== sv/aci_divider.sv =====
// Restoring divider, one quotient bit per cycle, unsigned magnitudes.
module aci_divider (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [aci_pkg::NUM_W-1:0]       dividend,
   input  logic [aci_pkg::DRAW_W-1:0]      divisor,
   output logic                            done,
   output logic [aci_pkg::NUM_W-1:0]       quotient
);

   localparam int CNT_W = $clog2(aci_pkg::NUM_W + 1);

   logic [aci_pkg::NUM_W-1:0]  quo_ff, quo_in;
   logic [aci_pkg::DRAW_W:0]   rem_ff, rem_in, rem_sh;
   logic [aci_pkg::DRAW_W-1:0] div_ff;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic                       run_ff, run_in, done_ff, done_in;

   assign rem_sh = {rem_ff[aci_pkg::DRAW_W-1:0], quo_ff[aci_pkg::NUM_W-1]};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         cnt_in = CNT_W'(aci_pkg::NUM_W);
         run_in = 1'b1;
      end else if (run_ff) begin
         if (rem_sh >= {1'b0, div_ff}) begin
            rem_in = rem_sh - {1'b0, div_ff};
            quo_in = {quo_ff[aci_pkg::NUM_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            quo_in = {quo_ff[aci_pkg::NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) div_ff <= divisor;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      if (reset) begin
         cnt_ff  <= '0;
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== sv/adc_table_interpolator_unit.sv =====
// Top level: breakpoint cell chain, multiplier stage, divider and output register.
// A load beat (req_type 0) writes one entry and leaves busy low.
// A convert beat holds busy high while the probe walks the cell chain one cell per
// cycle, the multiply state forms the product, the divide-start state launches the
// restoring divider, and the result is formed, saturated and registered when the
// divider finishes. The result is shown for one cycle with rsp_strobe; the
// receiver cannot stall it. Entries at indexes of TABLE_DEPTH or more are ignored.
module adc_table_interpolator_unit #(
   parameter int TABLE_DEPTH = 32,
   parameter int FULL_SCALE  = 4095
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_type,
   input  logic [aci_pkg::IDX_W-1:0]           req_entry_index,
   input  logic [aci_pkg::RAW_W-1:0]           req_entry_raw,
   input  logic signed [aci_pkg::TEMP_W-1:0]   req_entry_value,
   input  logic [aci_pkg::RAW_W-1:0]           req_raw_sample,
   output logic                                rsp_strobe,
   output logic signed [aci_pkg::OUT_W-1:0]    rsp_temperature
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SEARCH = 3'd1;
   localparam logic [2:0] ST_MUL    = 3'd2;
   localparam logic [2:0] ST_DIVGO  = 3'd3;
   localparam logic [2:0] ST_DIV    = 3'd4;

   localparam int SUM_W = aci_pkg::SUM_W;
   localparam logic signed [SUM_W-1:0] OUT_MAX = SUM_W'((1 << (aci_pkg::OUT_W-1)) - 1);
   localparam logic signed [SUM_W-1:0] OUT_MIN = -SUM_W'(1 << (aci_pkg::OUT_W-1));

   logic [2:0]         state_ff, state_in;
   aci_pkg::probe_type probe [TABLE_DEPTH+1];
   aci_pkg::probe_type hit_ff;
   logic [aci_pkg::RAW_W-1:0]         own_raw  [TABLE_DEPTH];
   logic signed [aci_pkg::TEMP_W-1:0] own_temp [TABLE_DEPTH];
   logic accept, div_done;

   logic signed [aci_pkg::DRAW_W-1:0] dsr, draw;
   logic signed [aci_pkg::DV_W-1:0]   dv;
   logic signed [aci_pkg::PROD_W-1:0] prod_ff;
   logic signed [aci_pkg::DRAW_W-1:0] draw_ff;
   logic signed [aci_pkg::NUM_W-1:0]  num;
   logic [aci_pkg::NUM_W-1:0]         num_mag, quo_mag;
   logic [aci_pkg::DRAW_W-1:0]        draw_mag;
   logic                              neg_ff, skip_ff;
   logic signed [SUM_W-1:0]           q_s, sum;
   logic signed [aci_pkg::OUT_W-1:0]  res;
   logic                              strobe_ff;
   logic signed [aci_pkg::OUT_W-1:0]  temp_ff;

   assign accept = start && !busy;
   assign busy   = (state_ff != ST_IDLE);

   always_comb begin
      probe[0]        = '0;
      probe[0].valid  = accept && (req_type == aci_pkg::REQ_CONVERT);
      probe[0].sample = req_raw_sample;
   end

   for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
      localparam int NX = (k == TABLE_DEPTH-1) ? k : k + 1;
      aci_cell #(
         .FULL_SCALE(FULL_SCALE),
         .IS_FIRST  (k == 0),
         .IS_LAST   (k == TABLE_DEPTH-1)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .wr_en    (accept && (req_type == aci_pkg::REQ_LOAD) && (32'(req_entry_index) == k)),
         .wr_raw   (req_entry_raw),
         .wr_temp  (req_entry_value),
         .next_raw (own_raw[NX]),
         .next_temp(own_temp[NX]),
         .own_raw  (own_raw[k]),
         .own_temp (own_temp[k]),
         .probe_in (probe[k]),
         .probe_out(probe[k+1])
      );
   end

   assign dsr  = $signed({1'b0, hit_ff.sample}) - $signed({1'b0, hit_ff.lo_raw});
   assign draw = $signed({1'b0, hit_ff.hi_raw}) - $signed({1'b0, hit_ff.lo_raw});
   assign dv   = aci_pkg::DV_W'(hit_ff.hi_temp) - aci_pkg::DV_W'(hit_ff.lo_temp);

   assign num      = {prod_ff, {aci_pkg::SCALE_SH{1'b0}}};
   assign num_mag  = num[aci_pkg::NUM_W-1] ? aci_pkg::NUM_W'(-num) : aci_pkg::NUM_W'(num);
   assign draw_mag = draw_ff[aci_pkg::DRAW_W-1] ? aci_pkg::DRAW_W'(-draw_ff)
                                                : aci_pkg::DRAW_W'(draw_ff);

   aci_divider u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (state_ff == ST_DIVGO),
      .dividend(num_mag),
      .divisor (draw_mag),
      .done    (div_done),
      .quotient(quo_mag)
   );

   always_comb begin
      q_s = $signed({2'b00, quo_mag});
      if (neg_ff) q_s = -q_s;
      if (skip_ff) q_s = '0;
      sum = SUM_W'($signed({hit_ff.lo_temp, {aci_pkg::SCALE_SH{1'b0}}})) + q_s;
      if (sum > OUT_MAX) res = aci_pkg::OUT_W'(OUT_MAX);
      else if (sum < OUT_MIN) res = aci_pkg::OUT_W'(OUT_MIN);
      else res = aci_pkg::OUT_W'(sum);
      if (hit_ff.sample == '0) res = '0;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (probe[0].valid) state_in = ST_SEARCH;
         ST_SEARCH: if (probe[TABLE_DEPTH].valid) state_in = ST_MUL;
         ST_MUL:    state_in = ST_DIVGO;
         ST_DIVGO:  state_in = ST_DIV;
         ST_DIV:    if (div_done) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (probe[TABLE_DEPTH].valid) hit_ff <= probe[TABLE_DEPTH];
      if (state_ff == ST_MUL) begin
         prod_ff <= dsr * dv;
         draw_ff <= draw;
         skip_ff <= hit_ff.direct || (draw == '0);
      end
      if (state_ff == ST_DIVGO) begin
         neg_ff <= prod_ff[aci_pkg::PROD_W-1] ^ draw_ff[aci_pkg::DRAW_W-1];
      end
      if (state_ff == ST_DIV && div_done) temp_ff <= res;
      if (reset) begin
         state_ff  <= ST_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= (state_ff == ST_DIV) && div_done;
      end
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_temperature = temp_ff;

   a_chain_end_in_search: assert property (@(posedge clock) disable iff (reset)
      probe[TABLE_DEPTH].valid |-> state_ff == ST_SEARCH)
      else $error("probe left chain outside search");

   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIV)
      else $error("divider finished outside divide phase");

   a_idle_after_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result beat while still busy");

endmodule

// ===== tb/sv/tb_adc_table_interpolator_unit.sv =====
// Testbench for adc_table_interpolator_unit: directed and random table loads and conversions.
`timescale 1ns / 100ps

module tb_adc_table_interpolator_unit;

   localparam int DEPTH      = 32;
   localparam int FULL       = 4095;
   localparam int CYCLE_CAP  = 1000000;
   localparam int DRAIN      = 120;
   localparam int ITEM_GOAL  = 1800;

   typedef struct {
      logic                              kind;
      logic [aci_pkg::IDX_W-1:0]         idx;
      logic [aci_pkg::RAW_W-1:0]         raw;
      logic signed [aci_pkg::TEMP_W-1:0] val;
      logic [aci_pkg::RAW_W-1:0]         sample;
   } beat_type;

   logic                              clock;
   logic                              reset;
   logic                              start;
   logic                              busy;
   logic                              req_type;
   logic [aci_pkg::IDX_W-1:0]         req_entry_index;
   logic [aci_pkg::RAW_W-1:0]         req_entry_raw;
   logic signed [aci_pkg::TEMP_W-1:0] req_entry_value;
   logic [aci_pkg::RAW_W-1:0]         req_raw_sample;
   logic                              rsp_strobe;
   logic signed [aci_pkg::OUT_W-1:0]  rsp_temperature;

   beat_type                          pending[$];
   logic signed [aci_pkg::OUT_W-1:0]  temp_expected[$];
   logic [aci_pkg::RAW_W-1:0]         bp_raw[DEPTH];
   logic signed [aci_pkg::TEMP_W-1:0] bp_val[DEPTH];
   logic [aci_pkg::RAW_W-1:0]         plan_raw[DEPTH];
   int                                error_count = 0;
   int                                cycle_count = 0;
   int                                wait_cnt = 0;
   bit                                no_idle = 0;
   bit                                stim_done = 0;

   adc_table_interpolator_unit u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_type(req_type), .req_entry_index(req_entry_index),
      .req_entry_raw(req_entry_raw), .req_entry_value(req_entry_value),
      .req_raw_sample(req_raw_sample), .rsp_strobe(rsp_strobe),
      .rsp_temperature(rsp_temperature)
   );

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   function automatic logic signed [aci_pkg::OUT_W-1:0] interpolate_temp(
         logic [aci_pkg::RAW_W-1:0] s);
      int     i;
      int     lo;
      int     hi;
      longint draw;
      longint num;
      longint acc;
      if (s == 0) return '0;
      for (i = 0; i < DEPTH - 1; i++)
         if (bp_raw[i] >= s) break;
      if (bp_raw[i] == s || bp_raw[i] >= FULL)
         return aci_pkg::OUT_W'(longint'(bp_val[i]) * 256);
      lo = (i > 0) ? i - 1 : 0;
      hi = (i > 0) ? i : 1;
      draw = longint'(bp_raw[hi]) - longint'(bp_raw[lo]);
      if (draw == 0) return aci_pkg::OUT_W'(longint'(bp_val[lo]) * 256);
      num = (longint'(s) - longint'(bp_raw[lo]))
            * (longint'(bp_val[hi]) - longint'(bp_val[lo])) * 256;
      acc = longint'(bp_val[lo]) * 256 + num / draw;
      if (acc > 8388607) acc = 8388607;
      if (acc < -8388608) acc = -8388608;
      return aci_pkg::OUT_W'(acc);
   endfunction

   function automatic logic signed [aci_pkg::TEMP_W-1:0] pick_value(int style);
      case (style)
         0: return aci_pkg::TEMP_W'($urandom);
         1: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
         default: return $signed(16'($urandom_range(0, 4000))) - 16'sd1000;
      endcase
   endfunction

   task automatic add_load(int idx, logic [aci_pkg::RAW_W-1:0] raw,
                           logic signed [aci_pkg::TEMP_W-1:0] val);
      beat_type b;
      b.kind = aci_pkg::REQ_LOAD; b.idx = aci_pkg::IDX_W'(idx); b.raw = raw; b.val = val;
      b.sample = aci_pkg::RAW_W'($urandom);
      pending.push_back(b);
   endtask

   task automatic add_convert(logic [aci_pkg::RAW_W-1:0] s);
      beat_type b;
      b.kind = aci_pkg::REQ_CONVERT; b.idx = aci_pkg::IDX_W'($urandom);
      b.raw = aci_pkg::RAW_W'($urandom); b.val = aci_pkg::TEMP_W'($urandom);
      b.sample = s;
      pending.push_back(b);
   endtask

   // fill plan_raw with a table shape, then queue all entries in random order
   task automatic load_table(int shape, int vstyle);
      logic [aci_pkg::RAW_W-1:0] sorted[$];
      int                        order[$];
      int                        k;
      int                        j;
      int                        t;
      for (k = 0; k < DEPTH - 1; k++)
         sorted.push_back(aci_pkg::RAW_W'($urandom_range(1, FULL - 1)));
      if (shape == 2) for (k = 0; k < 6; k++) sorted[$urandom_range(1, DEPTH - 2)] = sorted[0];
      if (shape != 1) sorted.sort();
      sorted.push_back(shape == 3 ? aci_pkg::RAW_W'($urandom_range(1, FULL - 1))
                                  : aci_pkg::RAW_W'(FULL));
      for (k = 0; k < DEPTH; k++) begin
         plan_raw[k] = sorted[k];
         order.push_back(k);
      end
      for (k = DEPTH - 1; k > 0; k--) begin
         j = $urandom_range(0, k);
         t = order[k]; order[k] = order[j]; order[j] = t;
      end
      foreach (order[k]) add_load(order[k], plan_raw[order[k]], pick_value(vstyle));
   endtask

   function automatic logic [aci_pkg::RAW_W-1:0] pick_sample();
      logic [aci_pkg::RAW_W-1:0] r;
      r = plan_raw[$urandom_range(0, DEPTH - 1)];
      case ($urandom_range(0, 9))
         0: return '0;
         1: return aci_pkg::RAW_W'(FULL);
         2, 3: return r;
         4: return r + 1'b1;
         5: return r - 1'b1;
         default: return aci_pkg::RAW_W'($urandom);
      endcase
   endfunction

   initial begin
      int k;
      int n;
      reset = 1;
      start = 0;
      req_type = aci_pkg::REQ_LOAD;
      req_entry_index = '0;
      req_entry_raw = '0;
      req_entry_value = '0;
      req_raw_sample = '0;
      // directed: ascending table, extreme values, then edge samples
      for (k = 0; k < DEPTH; k++) begin
         plan_raw[k] = (k == DEPTH - 1) ? aci_pkg::RAW_W'(FULL) : aci_pkg::RAW_W'(k * 128 + 1);
         add_load(k, plan_raw[k], (k % 2) ? 16'sh7FFF : 16'sh8000);
      end
      add_convert(12'd0);
      add_convert(12'd1);
      add_convert(aci_pkg::RAW_W'(FULL));
      add_convert(aci_pkg::RAW_W'(FULL - 1));
      add_convert(12'd129);
      add_convert(12'd130);
      add_convert(12'd200);
      add_convert(12'd2000);
      add_convert(plan_raw[DEPTH - 2] + 12'd5);
      add_load(3, 12'd385, 16'sh0000);
      add_load(4, 12'd385, 16'sh7FFF);
      add_convert(12'd385);
      add_convert(12'd400);
      add_load(5, 12'd100, 16'sh8000);
      add_convert(12'd600);
      add_convert(12'd700);
      while (pending.size() < ITEM_GOAL) begin
         k = $urandom_range(0, 9);
         load_table(k < 6 ? 0 : k - 5, $urandom_range(0, 2));
         n = $urandom_range(15, 50);
         repeat (n) begin
            if ($urandom_range(0, 15) == 0) begin
               k = $urandom_range(0, DEPTH - 2);
               plan_raw[k] = aci_pkg::RAW_W'($urandom);
               add_load(k, plan_raw[k], pick_value($urandom_range(0, 2)));
            end else begin
               add_convert(pick_sample());
            end
         end
      end
      repeat (5) @(posedge clock);
      reset <= 0;
      while (pending.size() != 0 || start || temp_expected.size() != 0)
         @(posedge clock);
      repeat (DRAIN) @(posedge clock);
      if (error_count == 0 && temp_expected.size() == 0)
         $display("adc_table_interpolator_unit test passed");
      else
         $display("adc_table_interpolator_unit test failed");
      $finish;
   end

   always @(posedge clock) begin
      beat_type b;
      bit       accepted;
      bit       launch;
      accepted = start && !busy;
      launch = 0;
      if (!reset) begin
         if (accepted) begin
            if (req_type == aci_pkg::REQ_LOAD) begin
               bp_raw[req_entry_index] = req_entry_raw;
               bp_val[req_entry_index] = req_entry_value;
            end else begin
               temp_expected.push_back(interpolate_temp(req_raw_sample));
            end
            if ($urandom_range(0, 99) == 0) no_idle = !no_idle;
            wait_cnt = no_idle ? 0 : $urandom_range(0, 6);
         end
         if (accepted || !start) begin
            if (wait_cnt > 0 && !accepted) wait_cnt--;
            if (wait_cnt == 0 && pending.size() != 0) launch = 1;
            else if (accepted) wait_cnt = wait_cnt;
         end
         if (launch) begin
            b = pending.pop_front();
            start <= 1;
            req_type <= b.kind;
            req_entry_index <= b.idx;
            req_entry_raw <= b.raw;
            req_entry_value <= b.val;
            req_raw_sample <= b.sample;
         end else if (accepted) begin
            start <= 0;
         end
      end
   end

   always @(posedge clock) begin
      logic signed [aci_pkg::OUT_W-1:0] want;
      if (!reset && rsp_strobe) begin
         if (temp_expected.size() == 0) begin
            $display("%0t: unexpected beat, expected none, actual temperature %0d",
                     $time, rsp_temperature);
            error_count++;
         end else begin
            want = temp_expected.pop_front();
            if (rsp_temperature !== want) begin
               $display("%0t: temperature mismatch, expected %0d, actual %0d",
                        $time, want, rsp_temperature);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_CAP) begin
         $display("adc_table_interpolator_unit test failed");
         $finish;
      end
   end

endmodule
